// File: hw/rtl/ofa_pkg.sv
package ofa_pkg;

    // Result magnitude width: Q2.14 values reach 16384, so fifteen bits.
    localparam int QW = 15;
    // Signed width of the running products in the cells (values stay below 2^95).
    localparam int WW = 98;
    // Width of the scaled square of the numerator (below 2^93).
    localparam int MW = 93;
    // One cell resolves one result bit.
    localparam int NCELL = 15;
    // Nine matrix entries: lanes 0..2 row x, 3..5 row y, 6..8 row z.
    localparam int NLANE = 9;
    // Cycles from the accepting edge to the edge that sampling sees o_valid.
    localparam int LATENCY = 19;

    localparam logic [QW-1:0] QONE = 15'd16384;

    // One matrix entry on its way down the chain.
    typedef struct packed {
        logic signed [WW-1:0] p;    // e^2 * N for the current estimate
        logic signed [WW-1:0] f;    // e * N, pre-shifted for this bit
        logic signed [WW-1:0] k;    // N, pre-shifted for this bit
        logic [MW-1:0]        m;    // val^2 * 2^30
        logic [QW-1:0]        qbit; // trial bit of this cell
        logic [QW-1:0]        q;    // magnitude found so far
        logic                 neg;  // sign of the entry
    } t_lane;

    // One beat as it moves through the chain.
    typedef struct packed {
        t_lane [NLANE-1:0] lane;
        logic              err;
    } t_beat;

endpackage

// File: hw/rtl/ofa_front.sv
module ofa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic signed [15:0]  i_a,
    input  logic signed [15:0]  i_b,
    input  logic signed [15:0]  i_c,
    output logic                o_vld,
    output ofa_pkg::t_beat      o_beat
);

    // Stage 1: squares, cross products, helper choice, zero-axis flag.
    logic               r_vld1;
    logic signed [15:0] r_a1, r_b1, r_c1;
    logic [31:0]        r_aa, r_bb, r_cc;
    logic signed [31:0] r_ab, r_ac, r_bc;
    logic               r_sel1, r_err1;
    logic [16:0]        abs_a, abs_b;

    always_comb begin
        abs_a = i_a[15] ? 17'(-$signed({i_a[15], i_a})) : {1'b0, i_a};
        abs_b = i_b[15] ? 17'(-$signed({i_b[15], i_b})) : {1'b0, i_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_a1   <= i_a;
        r_b1   <= i_b;
        r_c1   <= i_c;
        r_aa   <= 32'(i_a * i_a);
        r_bb   <= 32'(i_b * i_b);
        r_cc   <= 32'(i_c * i_c);
        r_ab   <= i_a * i_b;
        r_ac   <= i_a * i_c;
        r_bc   <= i_b * i_c;
        r_sel1 <= (abs_a <= abs_b);
        r_err1 <= (i_a == 16'sd0) && (i_b == 16'sd0) && (i_c == 16'sd0);
    end

    // Stage 2: norms and the numerators of all nine entries.
    logic               r_vld2, r_err2;
    logic [31:0]        r_s2, r_t2;
    logic signed [32:0] r_val [ofa_pkg::NLANE];
    logic signed [32:0] ea, eb, ec, t_ext;
    logic [31:0]        t_sum;

    always_comb begin
        ea    = 33'(r_a1);
        eb    = 33'(r_b1);
        ec    = 33'(r_c1);
        t_sum = r_sel1 ? (r_bb + r_cc) : (r_aa + r_cc);
        t_ext = $signed({1'b0, t_sum});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        r_err2 <= r_err1;
        r_s2   <= r_aa + r_bb + r_cc;
        r_t2   <= t_sum;
        if (r_sel1) begin
            r_val[0] <= 33'sd0;
            r_val[1] <= 33'sd0 - ec;
            r_val[2] <= eb;
            r_val[3] <= t_ext;
            r_val[4] <= 33'sd0 - 33'(r_ab);
            r_val[5] <= 33'sd0 - 33'(r_ac);
        end else begin
            r_val[0] <= ec;
            r_val[1] <= 33'sd0;
            r_val[2] <= 33'sd0 - ea;
            r_val[3] <= 33'sd0 - 33'(r_ab);
            r_val[4] <= t_ext;
            r_val[5] <= 33'sd0 - 33'(r_bc);
        end
        r_val[6] <= ea;
        r_val[7] <= eb;
        r_val[8] <= ec;
    end

    // Stage 3: squared numerators and the product norm of row y.
    logic        r_vld3, r_err3;
    logic [31:0] r_s3, r_t3;
    logic [63:0] r_st;
    logic [63:0] r_mm  [ofa_pkg::NLANE];
    logic        r_neg [ofa_pkg::NLANE];
    logic [31:0] mag   [ofa_pkg::NLANE];

    always_comb begin
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            mag[l] = r_val[l][32] ? 32'(-r_val[l]) : 32'(r_val[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
        r_err3 <= r_err2;
        r_s3   <= r_s2;
        r_t3   <= r_t2;
        r_st   <= 64'(r_s2) * 64'(r_t2);
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            r_mm[l]  <= 64'(mag[l]) * 64'(mag[l]);
            r_neg[l] <= r_val[l][32];
        end
    end

    // Starting point of the bit search: estimate zero, so e = -1.
    logic [63:0] nrm [ofa_pkg::NLANE];

    always_comb begin
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            if (l < 3) begin
                nrm[l] = 64'(r_t3);
            end else if (l < 6) begin
                nrm[l] = r_st;
            end else begin
                nrm[l] = 64'(r_s3);
            end
        end
        o_vld       = r_vld3;
        o_beat.err  = r_err3;
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            o_beat.lane[l].p    = ofa_pkg::WW'(nrm[l]);
            o_beat.lane[l].f    = -$signed(ofa_pkg::WW'({nrm[l], 16'd0}));
            o_beat.lane[l].k    = ofa_pkg::WW'({nrm[l], 30'd0});
            o_beat.lane[l].m    = ofa_pkg::MW'({r_mm[l], 30'd0});
            o_beat.lane[l].qbit = ofa_pkg::QONE;
            o_beat.lane[l].q    = '0;
            o_beat.lane[l].neg  = r_neg[l];
        end
    end

endmodule

// File: hw/rtl/ofa_cell.sv
module ofa_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  ofa_pkg::t_beat i_beat,
    output logic           o_vld,
    output ofa_pkg::t_beat o_beat
);

    logic                          r_vld;
    ofa_pkg::t_beat                r_beat;
    ofa_pkg::t_beat                n_beat;
    logic signed [ofa_pkg::WW-1:0] cand [ofa_pkg::NLANE];
    logic [ofa_pkg::QW:0]          trial [ofa_pkg::NLANE];
    logic                          take [ofa_pkg::NLANE];

    // Keep this cell's bit when (2q-1)^2 * N <= val^2 * 2^30 and q <= QONE.
    // Moving to the next bit halves the e*N term and quarters the N term.
    always_comb begin
        n_beat = i_beat;
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            cand[l]  = i_beat.lane[l].p + i_beat.lane[l].f + i_beat.lane[l].k;
            trial[l] = {1'b0, i_beat.lane[l].q} + {1'b0, i_beat.lane[l].qbit};
            take[l]  = (cand[l] <= $signed(ofa_pkg::WW'(i_beat.lane[l].m)))
                       && (trial[l] <= {1'b0, ofa_pkg::QONE});
            if (take[l]) begin
                n_beat.lane[l].p = cand[l];
                n_beat.lane[l].q = trial[l][ofa_pkg::QW-1:0];
                n_beat.lane[l].f = (i_beat.lane[l].f >>> 1) + i_beat.lane[l].k;
            end else begin
                n_beat.lane[l].f = i_beat.lane[l].f >>> 1;
            end
            n_beat.lane[l].k    = i_beat.lane[l].k >>> 2;
            n_beat.lane[l].qbit = i_beat.lane[l].qbit >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_beat <= n_beat;
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;

endmodule

// File: hw/rtl/orthonormal_frame_from_axis_unit.sv
// Throughput: one beat per cycle; o_busy stays low, so start may be high every cycle.
// An accepted start passes through three front stages, fifteen search cells (one result
// bit each) and one output register before its result is strobed on o_valid. Reset
// (i_rst_n low, synchronous) clears all valid flags; results are not held: the receiver
// cannot stall and takes each strobe as it comes.
module orthonormal_frame_from_axis_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_axis_x,
    input  logic signed [15:0] i_axis_y,
    input  logic signed [15:0] i_axis_z,
    output logic               o_valid,
    output logic signed [15:0] o_row_x_0,
    output logic signed [15:0] o_row_x_1,
    output logic signed [15:0] o_row_x_2,
    output logic signed [15:0] o_row_y_0,
    output logic signed [15:0] o_row_y_1,
    output logic signed [15:0] o_row_y_2,
    output logic signed [15:0] o_row_z_0,
    output logic signed [15:0] o_row_z_1,
    output logic signed [15:0] o_row_z_2,
    output logic               o_zero_axis_error
);

    // The pipeline never stalls.
    assign o_busy = 1'b0;

    // Front stages.
    logic           vld [ofa_pkg::NCELL+1];
    ofa_pkg::t_beat beat [ofa_pkg::NCELL+1];

    ofa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_a     (i_axis_x),
        .i_b     (i_axis_y),
        .i_c     (i_axis_z),
        .o_vld   (vld[0]),
        .o_beat  (beat[0])
    );

    // Chain of search cells, most significant bit first.
    for (genvar g = 0; g < ofa_pkg::NCELL; g++) begin : g_cell
        ofa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld[g]),
            .i_beat  (beat[g]),
            .o_vld   (vld[g+1]),
            .o_beat  (beat[g+1])
        );
    end

    // Apply signs, force zeros on a zero axis, and register the result.
    logic               r_valid;
    logic               r_err;
    logic signed [15:0] r_ent [ofa_pkg::NLANE];
    logic signed [15:0] n_ent [ofa_pkg::NLANE];
    logic signed [15:0] mag16 [ofa_pkg::NLANE];

    always_comb begin
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            mag16[l] = $signed({1'b0, beat[ofa_pkg::NCELL].lane[l].q});
            if (beat[ofa_pkg::NCELL].err) begin
                n_ent[l] = 16'sd0;
            end else if (beat[ofa_pkg::NCELL].lane[l].neg) begin
                n_ent[l] = -mag16[l];
            end else begin
                n_ent[l] = mag16[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= vld[ofa_pkg::NCELL];
        end
        r_err <= beat[ofa_pkg::NCELL].err;
        for (int l = 0; l < ofa_pkg::NLANE; l++) begin
            r_ent[l] <= n_ent[l];
        end
    end

    assign o_valid           = r_valid;
    assign o_zero_axis_error = r_err;
    assign o_row_x_0         = r_ent[0];
    assign o_row_x_1         = r_ent[1];
    assign o_row_x_2         = r_ent[2];
    assign o_row_y_0         = r_ent[3];
    assign o_row_y_1         = r_ent[4];
    assign o_row_y_2         = r_ent[5];
    assign o_row_z_0         = r_ent[6];
    assign o_row_z_1         = r_ent[7];
    assign o_row_z_2         = r_ent[8];

`ifndef SYNTHESIS
    // Every result beat traces back to an accepted start.
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, ofa_pkg::LATENCY))
        else $error("result beat without a matching start");

    // A zero axis gives an all-zero matrix.
    a_zero_matrix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_axis_error) |->
            (o_row_x_0 == 16'sd0 && o_row_x_1 == 16'sd0 && o_row_x_2 == 16'sd0 &&
             o_row_y_0 == 16'sd0 && o_row_y_1 == 16'sd0 && o_row_y_2 == 16'sd0 &&
             o_row_z_0 == 16'sd0 && o_row_z_1 == 16'sd0 && o_row_z_2 == 16'sd0))
        else $error("nonzero entry on a zero axis");

    // Unit rows: no entry of row z exceeds one in magnitude.
    a_row_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_z_0 <= 16'sd16384 && o_row_z_0 >= -16'sd16384 &&
                     o_row_z_1 <= 16'sd16384 && o_row_z_1 >= -16'sd16384 &&
                     o_row_z_2 <= 16'sd16384 && o_row_z_2 >= -16'sd16384))
        else $error("row z entry out of range");

    // The helper choice always leaves one zero entry in row x.
    a_row_x_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_row_x_0 == 16'sd0 || o_row_x_1 == 16'sd0))
        else $error("row x has no zero entry");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        bit                 drain;
    } t_axis_item;

    typedef struct {
        logic signed [15:0] entry [9];
        logic               err;
    } t_frame;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [15:0] i_axis_x;
    logic signed [15:0] i_axis_y;
    logic signed [15:0] i_axis_z;
    logic               o_valid;
    logic signed [15:0] o_row_x_0, o_row_x_1, o_row_x_2;
    logic signed [15:0] o_row_y_0, o_row_y_1, o_row_y_2;
    logic signed [15:0] o_row_z_0, o_row_z_1, o_row_z_2;
    logic               o_zero_axis_error;

    t_axis_item pending_axes[$];
    t_frame     expected_frames[$];
    bit         beat_taken;
    int         sent_count;
    int         fail_count;
    int         quiet_cycles;

    orthonormal_frame_from_axis_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_axis_x(i_axis_x), .i_axis_y(i_axis_y), .i_axis_z(i_axis_z),
        .o_valid(o_valid),
        .o_row_x_0(o_row_x_0), .o_row_x_1(o_row_x_1), .o_row_x_2(o_row_x_2),
        .o_row_y_0(o_row_y_0), .o_row_y_1(o_row_y_1), .o_row_y_2(o_row_y_2),
        .o_row_z_0(o_row_z_0), .o_row_z_1(o_row_z_1), .o_row_z_2(o_row_z_2),
        .o_zero_axis_error(o_zero_axis_error)
    );

    // Rounds 16384 * val / sqrt(norm2) to nearest, ties away from zero, by bisection.
    function automatic logic signed [15:0] q14_ratio(longint val, logic [127:0] norm2);
        logic [127:0] mag;
        logic [127:0] scaled_sq;
        logic [127:0] trial;
        logic [127:0] d;
        longint       lo;
        longint       hi;
        longint       mid;
        mag = (val < 0) ? 128'(-val) : 128'(val);
        scaled_sq = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 128'(2 * mid - 1);
            trial = d * d * norm2;
            if (trial <= scaled_sq) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (val < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    // Builds the frame: z is the normalized axis, x from the helper, y = z cross x.
    function automatic t_frame frame_from_axis(logic signed [15:0] ax, logic signed [15:0] ay,
                                               logic signed [15:0] az);
        t_frame       fr;
        longint       a;
        longint       b;
        longint       c;
        longint       u [3];
        longint       w [3];
        logic [127:0] s;
        logic [127:0] t;
        a = ax;
        b = ay;
        c = az;
        if (a == 0 && b == 0 && c == 0) begin
            foreach (fr.entry[k]) fr.entry[k] = '0;
            fr.err = 1'b1;
            return fr;
        end
        s = 128'(a * a + b * b + c * c);
        if ((a < 0 ? -a : a) <= (b < 0 ? -b : b)) begin
            u[0] = 0; u[1] = -c; u[2] = b;
            t = 128'(b * b + c * c);
            w[0] = b * b + c * c; w[1] = -(a * b); w[2] = -(a * c);
        end else begin
            u[0] = c; u[1] = 0; u[2] = -a;
            t = 128'(a * a + c * c);
            w[0] = -(a * b); w[1] = a * a + c * c; w[2] = -(b * c);
        end
        for (int k = 0; k < 3; k++) begin
            fr.entry[k]     = q14_ratio(u[k], t);
            fr.entry[3 + k] = q14_ratio(w[k], s * t);
        end
        fr.entry[6] = q14_ratio(a, s);
        fr.entry[7] = q14_ratio(b, s);
        fr.entry[8] = q14_ratio(c, s);
        fr.err = 1'b0;
        return fr;
    endfunction

    function automatic logic signed [15:0] rand_component();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 7)) - 16'sd3;
            1: return 16'sh8000;
            2: return 16'sh7fff;
            3: return 16'($urandom_range(0, 511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_axis(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az, bit drain);
        t_axis_item it;
        it.ax = ax;
        it.ay = ay;
        it.az = az;
        it.drain = drain;
        pending_axes.push_back(it);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Driver: one beat offered per falling edge, with occasional idle cycles and a wait before a drain item.
    always @(negedge i_clk) begin
        bit offer;
        if (beat_taken) begin
            void'(pending_axes.pop_front());
            sent_count++;
        end
        offer = i_rst_n && pending_axes.size() > 0;
        if (offer && pending_axes[0].drain && expected_frames.size() > 0) offer = 0;
        if (offer && !(sent_count >= 300 && sent_count < 500) && $urandom_range(0, 99) < 6)
            offer = 0;
        if (offer) begin
            i_start  <= 1'b1;
            i_axis_x <= pending_axes[0].ax;
            i_axis_y <= pending_axes[0].ay;
            i_axis_z <= pending_axes[0].az;
        end else begin
            i_start  <= 1'b0;
            i_axis_x <= 16'($urandom);
            i_axis_y <= 16'($urandom);
            i_axis_z <= 16'($urandom);
        end
    end

    // Monitor: record accepted beats and check every strobed result.
    always @(posedge i_clk) begin
        t_frame got;
        t_frame want;
        bit     took;
        bit     seen;
        took = i_rst_n && i_start && !o_busy;
        seen = i_rst_n && o_valid;
        if (took) begin
            expected_frames.push_back(frame_from_axis(i_axis_x, i_axis_y, i_axis_z));
        end
        if (seen) begin
            got.entry = '{o_row_x_0, o_row_x_1, o_row_x_2, o_row_y_0, o_row_y_1,
                          o_row_y_2, o_row_z_0, o_row_z_1, o_row_z_2};
            got.err = o_zero_axis_error;
            if (expected_frames.size() == 0) begin
                $display("%0t: result with no beat pending", $time);
                fail_count++;
            end else begin
                want = expected_frames.pop_front();
                foreach (want.entry[k]) begin
                    if (got.entry[k] !== want.entry[k]) begin
                        $display("%0t: entry %0d expected %0d actual %0d",
                                 $time, k, want.entry[k], got.entry[k]);
                        fail_count++;
                    end
                end
                if (got.err !== want.err) begin
                    $display("%0t: zero_axis_error expected %0b actual %0b",
                             $time, want.err, got.err);
                    fail_count++;
                end
            end
        end
        beat_taken   <= took;
        quiet_cycles <= (took || seen) ? 0 : quiet_cycles + 1;
    end

    // Watchdog on cycles without any accepted beat or result.
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL orthonormal_frame_from_axis_unit");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_axis_x = '0;
        i_axis_y = '0;
        i_axis_z = '0;
        beat_taken = 1'b0;
        sent_count = 0;
        fail_count = 0;
        quiet_cycles = 0;

        // Directed: zero axis, extremes, unit axes and helper ties.
        add_axis(16'sd0, 16'sd0, 16'sd0, 0);
        add_axis(16'sh8000, 16'sh8000, 16'sh8000, 0);
        add_axis(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        add_axis(16'sh8000, 16'sh7fff, 16'sd0, 0);
        add_axis(16'sh7fff, 16'sh8000, 16'sh8000, 0);
        add_axis(16'sd1, 16'sd0, 16'sd0, 0);
        add_axis(16'sd0, 16'sd1, 16'sd0, 0);
        add_axis(16'sd0, 16'sd0, 16'sd1, 0);
        add_axis(-16'sd1, 16'sd0, 16'sd0, 0);
        add_axis(16'sd0, -16'sd1, 16'sd0, 0);
        add_axis(16'sd0, 16'sd0, -16'sd1, 0);
        add_axis(16'sd5, -16'sd5, 16'sd3, 0);
        add_axis(-16'sd7, 16'sd7, 16'sd0, 0);
        add_axis(16'sd0, 16'sd0, 16'sh8000, 0);
        add_axis(16'sh8000, 16'sd0, 16'sd0, 0);
        add_axis(16'sd3, 16'sd4, 16'sd12, 0);
        add_axis(16'sd1, 16'sd1, 16'sd1, 0);
        add_axis(16'sd0, 16'sd0, 16'sd0, 0);
        add_axis(16'sh7fff, 16'sd1, -16'sd1, 0);

        // Random axes, with a pause for a full drain partway through.
        for (int n = 0; n < 800; n++) begin
            logic signed [15:0] rx;
            logic signed [15:0] ry;
            logic signed [15:0] rz;
            rx = rand_component();
            ry = rand_component();
            rz = rand_component();
            if ($urandom_range(0, 9) == 0) ry = ($urandom_range(0, 1)) ? rx : -rx;
            if ($urandom_range(0, 49) == 0) begin
                rx = '0; ry = '0; rz = '0;
            end
            add_axis(rx, ry, rz, n == 150);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_axes.size() != 0 || expected_frames.size() != 0) @(posedge i_clk);
        repeat (ofa_pkg::LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS orthonormal_frame_from_axis_unit");
        end else begin
            $display("FAIL orthonormal_frame_from_axis_unit");
        end
        $finish;
    end

endmodule
